>>> hdl/numeric_literal_lexer_top_defines.svh
// Assertion macros for the numeric literal lexer.
// Used by the top level only; needs clock and reset in scope.
`ifndef NUMERIC_LITERAL_LEXER_TOP_DEFINES_SVH
`define NUMERIC_LITERAL_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, checked at each rising clock outside reset.
`define NLL_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, checked at each rising clock outside reset.
`define NLL_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> hdl/nll_pkg.sv
// Shared types and constants for the numeric literal lexer.
// No dependencies; imported by the front, queue, back and top modules.
package nll_pkg;

   localparam int FIELD_BITS     = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef enum logic [2:0] {
      PH_DONE,
      PH_START,
      PH_INT,
      PH_HEX,
      PH_FRAC,
      PH_EXPSTART,
      PH_EXPSCAN,
      PH_QUOTE
   } phase_type;

   // One classified character as it travels from the front to the back
   typedef struct packed {
      logic [7:0] code;
      logic       first;
      logic       is_digit;
      logic       is_hex;
      logic [3:0] nibble;
      logic       is_e;
      logic       is_dot;
      logic       is_plus;
      logic       is_minus;
      logic       is_x;
      logic       is_quote;
      logic       is_zero;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> hdl/nll_req_if.sv
// Input channel of the numeric literal lexer: one character per transaction.
// No dependencies.
interface nll_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       start_of_text;

   modport source (output valid, output char_code, output start_of_text, input ready);
   modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

>>> hdl/nll_rsp_if.sv
// Result channel of the numeric literal lexer: one parsed number per transaction.
// No dependencies.
interface nll_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] mantissa;
   logic               is_fraction;
   logic signed [31:0] dec_exponent;

   modport source (output valid, output mantissa, output is_fraction, output dec_exponent,
                   input ready);
   modport sink   (input valid, input mantissa, input is_fraction, input dec_exponent,
                   output ready);
endinterface

>>> hdl/numeric_literal_lexer_top.sv
// Numeric literal lexer: takes one character per transaction and returns one parsed
// number (wrapped mantissa, fraction flag, decimal exponent) per argument. A new
// character is taken every cycle as long as results are drained; the parser's
// state update in the back stage handles one character per cycle. The character
// that ends a number is registered in the classifying front register, then in the
// queue, and its result is then registered in the output register.
// The queue holds four characters, so either side may stall alone.
// Depends on nll_pkg, nll_req_if, nll_rsp_if, nll_front, nll_queue, nll_back
// and numeric_literal_lexer_top_defines.svh.
`include "numeric_literal_lexer_top_defines.svh"

module numeric_literal_lexer_top import nll_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   nll_req_if.sink   req_if,
   nll_rsp_if.source rsp_if
);

   logic             q_push;
   logic             q_pop;
   item_type         push_item;
   item_type         head_item;
   queue_status_type q_status;

   nll_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_status (q_status),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   nll_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   nll_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .item     (head_item),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_if   (rsp_if)
   );

   `NLL_ASSERT_NOW(a_no_push_full, q_push, !q_status.full, "push into full queue")
   `NLL_ASSERT_NOW(a_no_pop_stalled, rsp_if.valid && !rsp_if.ready, !q_pop,
                   "parser advanced while result stalled")
   `NLL_ASSERT_NOW(a_no_pop_empty, q_status.empty, !q_pop, "pop from empty queue")
   `NLL_ASSERT_NEXT(a_result_source, rsp_if.valid && rsp_if.ready && !q_pop, !rsp_if.valid,
                    "result appeared without a parsed character")

endmodule

>>> hdl/nll_front.sv
// Front stage: accepts characters, classifies them and pushes them to the queue.
// Depends on nll_pkg and nll_req_if.
module nll_front import nll_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   nll_req_if.sink          req_if,
   input  queue_status_type q_status,
   output logic             q_push,
   output item_type         q_item
);

   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_LO_X   = 8'h78;
   localparam logic [7:0] CH_UP_X   = 8'h58;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic     is_letter;

   assign req_if.ready = !valid_ff || !q_status.full;
   assign accept       = req_if.valid && req_if.ready;
   assign q_push       = valid_ff && !q_status.full;
   assign q_item       = item_ff;

   always_comb begin
      item_in.code     = req_if.char_code;
      item_in.first    = req_if.start_of_text;
      item_in.is_digit = req_if.char_code inside {[CH_ZERO:CH_NINE]};
      is_letter        = req_if.char_code inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
      item_in.is_hex   = item_in.is_digit || is_letter;
      // letters a-f and A-F share their low nibble: 1..6 maps to 10..15
      item_in.nibble   = is_letter ? req_if.char_code[3:0] + 4'd9 : req_if.char_code[3:0];
      item_in.is_e     = req_if.char_code inside {CH_LO_E, CH_UP_E};
      item_in.is_dot   = req_if.char_code == CH_DOT;
      item_in.is_plus  = req_if.char_code == CH_PLUS;
      item_in.is_minus = req_if.char_code == CH_MINUS;
      item_in.is_x     = req_if.char_code inside {CH_LO_X, CH_UP_X};
      item_in.is_quote = req_if.char_code inside {CH_APOS, CH_DQUOTE};
      item_in.is_zero  = req_if.char_code == CH_ZERO;
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> hdl/nll_queue.sv
// Short queue of classified characters between the front and back stages.
// Depends on nll_pkg.
module nll_queue import nll_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type status
);

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign status.full  = count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hdl/nll_back.sv
// Back stage: runs the number parser on queued characters and holds the result.
// Depends on nll_pkg and nll_rsp_if.
module nll_back import nll_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  item_type         item,
   input  queue_status_type q_status,
   output logic             q_pop,
   nll_rsp_if.source        rsp_if
);

   phase_type phase_ff, phase_in;
   logic [WORD_BITS-1:0] dec_ff, dec_in;
   logic [WORD_BITS-1:0] oct_ff, oct_in;
   logic [WORD_BITS-1:0] frac_exp_ff, frac_exp_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   logic                 neg_ff, neg_in;
   logic                 lz_ff, lz_in;
   logic                 exp_neg_ff, exp_neg_in;

   logic                    out_valid_ff, out_valid_in;
   logic signed [FIELD_BITS-1:0] mant_ff, mant_in;
   logic                    frac_ff, frac_in;
   logic signed [FIELD_BITS-1:0] dexp_ff, dexp_in;

   logic                 clr;
   logic                 int_mode;
   logic                 emit;
   logic [WORD_BITS-1:0] base_dec, base_oct, base_frac_exp, base_exp;
   logic                 base_neg, base_lz, base_exp_neg;
   logic [WORD_BITS-1:0] digit_w;
   logic [WORD_BITS-1:0] dec10, dec16, oct8, exp10;
   logic [WORD_BITS-1:0] mag;
   logic signed [WORD_BITS-1:0] mant_w, dexp_w;

   assign q_pop = !q_status.empty && (!out_valid_ff || rsp_if.ready);
   assign clr   = item.first;

   // Characters that continue the decimal part of a number
   assign int_mode = clr ? (item.is_digit || item.is_dot || item.is_e)
                         : (phase_ff == PH_INT ||
                            (phase_ff == PH_START && !(lz_ff && item.is_x)));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (q_pop) begin
         if (clr && (item.is_plus || item.is_minus || item.is_zero)) begin
            phase_in = PH_START;
         end else if (clr && item.is_quote) begin
            phase_in = PH_QUOTE;
         end else if (int_mode) begin
            if (item.is_digit) begin
               phase_in = PH_INT;
            end else if (item.is_e) begin
               phase_in = PH_EXPSTART;
            end else if (item.is_dot) begin
               phase_in = PH_FRAC;
            end else begin
               phase_in = PH_DONE;
            end
         end else if (clr) begin
            phase_in = PH_DONE;
         end else begin
            case (phase_ff)
               PH_START: begin
                  phase_in = PH_HEX;
               end
               PH_HEX: begin
                  phase_in = item.is_hex ? PH_HEX : PH_DONE;
               end
               PH_FRAC: begin
                  if (item.is_digit) begin
                     phase_in = PH_FRAC;
                  end else if (item.is_e) begin
                     phase_in = PH_EXPSTART;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_EXPSTART: begin
                  phase_in = (item.is_plus || item.is_minus || item.is_digit) ? PH_EXPSCAN
                                                                            : PH_DONE;
               end
               PH_EXPSCAN: begin
                  phase_in = item.is_digit ? PH_EXPSCAN : PH_DONE;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   assign emit = q_pop && phase_in == PH_DONE && (clr || phase_ff != PH_DONE);

   // Datapath updates and result
   always_comb begin
      base_dec      = clr ? '0 : dec_ff;
      base_oct      = clr ? '0 : oct_ff;
      base_frac_exp = clr ? '0 : frac_exp_ff;
      base_exp      = clr ? '0 : exp_ff;
      base_neg      = clr ? item.is_minus : neg_ff;
      base_lz       = clr ? item.is_zero : lz_ff;
      base_exp_neg  = clr ? 1'b0 : exp_neg_ff;
      digit_w       = WORD_BITS'(item.nibble);
      dec10 = (base_dec << 3) + (base_dec << 1) + digit_w;
      dec16 = (base_dec << 4) + digit_w;
      oct8  = (base_oct << 3) + digit_w;
      exp10 = (base_exp << 3) + (base_exp << 1) + digit_w;

      dec_in      = base_dec;
      oct_in      = base_oct;
      frac_exp_in = base_frac_exp;
      exp_in      = base_exp;
      neg_in      = base_neg;
      lz_in       = base_lz;
      exp_neg_in  = base_exp_neg;

      if (int_mode) begin
         if (item.is_digit) begin
            dec_in = dec10;
            oct_in = oct8;
         end
      end else if (!clr) begin
         case (phase_ff)
            PH_HEX: begin
               if (item.is_hex) begin
                  dec_in = dec16;
               end
            end
            PH_FRAC: begin
               if (item.is_digit) begin
                  dec_in      = dec10;
                  frac_exp_in = base_frac_exp - 1'b1;
               end
            end
            PH_EXPSTART: begin
               if (item.is_minus) begin
                  exp_neg_in = 1'b1;
               end else if (item.is_digit) begin
                  exp_in = exp10;
               end
            end
            PH_EXPSCAN: begin
               if (item.is_digit) begin
                  exp_in = exp10;
               end
            end
            default: begin
            end
         endcase
      end

      // Result fields, wrapped to the word and sign-extended from it
      mag    = (int_mode && base_lz) ? base_oct : base_dec;
      dexp_w = '0;
      frac_in = 1'b0;
      if (clr || phase_ff == PH_QUOTE) begin
         mant_w = WORD_BITS'(item.code);
      end else begin
         mant_w = base_neg ? -mag : mag;
      end
      if (!clr && phase_ff == PH_FRAC) begin
         frac_in = 1'b1;
         dexp_w  = base_frac_exp;
      end else if (!clr && (phase_ff == PH_EXPSTART || phase_ff == PH_EXPSCAN)) begin
         frac_in = 1'b1;
         dexp_w  = base_exp_neg ? base_frac_exp - base_exp : base_frac_exp + base_exp;
      end
      mant_in = FIELD_BITS'(mant_w);
      dexp_in = FIELD_BITS'(dexp_w);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         dec_ff       <= '0;
         oct_ff       <= '0;
         frac_exp_ff  <= '0;
         exp_ff       <= '0;
         neg_ff       <= 1'b0;
         lz_ff        <= 1'b0;
         exp_neg_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            phase_ff    <= phase_in;
            dec_ff      <= dec_in;
            oct_ff      <= oct_in;
            frac_exp_ff <= frac_exp_in;
            exp_ff      <= exp_in;
            neg_ff      <= neg_in;
            lz_ff       <= lz_in;
            exp_neg_ff  <= exp_neg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         mant_ff <= mant_in;
         frac_ff <= frac_in;
         dexp_ff <= dexp_in;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.mantissa     = mant_ff;
   assign rsp_if.is_fraction  = frac_ff;
   assign rsp_if.dec_exponent = dexp_ff;

endmodule
